[hw/rtl/spmv_pkg.sv]
// ============================================================================
// spmv_pkg
// Shared types and constants for the sparse coordinate-form matrix-vector
// accumulate block.
// ============================================================================
`default_nettype none

package spmv_pkg;

    // Field widths of one input item and one result item.
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * VAL_W;

    // Indices are widened to this many bits before the range check, enough to
    // hold the largest supported depth itself.
    localparam int IDX_EXT_W = 17;

    // Default number of vector and accumulator entries.
    localparam int DEFAULT_VECTOR_DEPTH = 1024;

    // Item kinds. The unused code is ignored and gives no result.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_MAC  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic fetch;
        logic exec;
        logic accum;
        logic clear;
    } t_ctrl_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_load;
        logic is_mac;
        logic is_read;
        logic in_range;
        logic clear_last;
    } t_dp_status;

endpackage

`default_nettype wire

[hw/rtl/spmv_ctrl.sv]
// ============================================================================
// spmv_ctrl
// Controller state machine: runs the accumulator clearing pass after reset
// and steps each accepted item through fetch, execute and accumulate as needed.
// ============================================================================
`default_nettype none

module spmv_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire spmv_pkg::t_dp_status i_status,
    output spmv_pkg::t_ctrl_cmd       o_cmd,
    output logic                      o_busy
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_ACCUM = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                if ((i_status.is_mac || i_status.is_read) && i_status.in_range) begin
                    n_state = ST_EXEC;
                end else if (i_status.is_read) begin
                    n_state = ST_EXEC;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_mac) begin
                    n_state = ST_ACCUM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/spmv_dp.sv]
// ============================================================================
// spmv_dp
// Datapath: item registers, vector store, accumulator store, multiplier,
// saturating accumulator, clearing counter and result registers.
// ============================================================================
`default_nettype none

module spmv_dp #(
    parameter int VECTOR_DEPTH = spmv_pkg::DEFAULT_VECTOR_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire spmv_pkg::t_ctrl_cmd                i_cmd,
    output spmv_pkg::t_dp_status                    o_status,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_data,
    input  wire logic [spmv_pkg::KIND_W-1:0]        i_kind,
    input  wire logic [spmv_pkg::IDX_W-1:0]         i_row_index,
    input  wire logic [spmv_pkg::IDX_W-1:0]         i_col_index,
    input  wire logic [spmv_pkg::IDX_W-1:0]         i_vec_index,
    input  wire logic signed [spmv_pkg::VAL_W-1:0]  i_value,
    output logic                                    o_result_valid,
    output logic [spmv_pkg::IDX_W-1:0]              o_out_index,
    output logic signed [spmv_pkg::ACC_W-1:0]       o_out_value,
    output logic                                    o_out_saturated
);

    localparam int AW     = $clog2(VECTOR_DEPTH);
    localparam int EW     = spmv_pkg::IDX_EXT_W;
    localparam int ACC_W  = spmv_pkg::ACC_W;
    localparam int ENT_W  = ACC_W + 1;
    localparam int VAL_W  = spmv_pkg::VAL_W;
    localparam int PROD_W = spmv_pkg::PROD_W;
    localparam int FRAC_W = spmv_pkg::FRAC_W;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Storage. Accumulator entries carry the sticky flag in the top bit.
    logic [VAL_W-1:0] r_vec_mem [VECTOR_DEPTH];
    logic [ENT_W-1:0] r_acc_mem [VECTOR_DEPTH];

    // Captured item.
    logic [spmv_pkg::KIND_W-1:0] r_kind;
    logic [spmv_pkg::IDX_W-1:0]  r_row;
    logic [spmv_pkg::IDX_W-1:0]  r_col;
    logic [spmv_pkg::IDX_W-1:0]  r_vidx;
    logic signed [VAL_W-1:0]     r_value;

    logic                        r_transpose;
    logic [AW-1:0]               r_clr_addr;
    logic [VAL_W-1:0]            r_vec_rd;
    logic [ENT_W-1:0]            r_acc_rd;
    logic signed [PROD_W-1:0]    r_prod;

    logic                        r_res_valid;
    logic [spmv_pkg::IDX_W-1:0]  r_res_index;
    logic [ACC_W-1:0]            r_res_value;
    logic                        r_res_sat;

    // Decoded item.
    logic [spmv_pkg::IDX_W-1:0] dst_idx;
    logic [spmv_pkg::IDX_W-1:0] src_idx;
    logic [EW-1:0]              dst_ext;
    logic [EW-1:0]              src_ext;
    logic [EW-1:0]              vidx_ext;
    logic                       is_load;
    logic                       is_mac;
    logic                       is_read;
    logic                       in_range;
    logic [AW-1:0]              vec_addr;
    logic [AW-1:0]              acc_addr;

    // Accumulate and write port of the accumulator store.
    logic [ENT_W-1:0]           sum;
    logic                       ovf;
    logic [ENT_W-1:0]           acc_new;
    logic                       acc_we;
    logic [AW-1:0]              acc_waddr;
    logic [ENT_W-1:0]           acc_wdata;

    // Source and destination follow the transpose setting.
    always_comb begin
        dst_idx  = r_transpose ? r_col : r_row;
        src_idx  = r_transpose ? r_row : r_col;
        dst_ext  = EW'(dst_idx);
        src_ext  = EW'(src_idx);
        vidx_ext = EW'(r_vidx);
        is_load  = (r_kind == spmv_pkg::KIND_LOAD);
        is_mac   = (r_kind == spmv_pkg::KIND_MAC);
        is_read  = (r_kind == spmv_pkg::KIND_READ);
        if (is_mac) begin
            in_range = (dst_ext < EW'(VECTOR_DEPTH)) && (src_ext < EW'(VECTOR_DEPTH));
            vec_addr = src_ext[AW-1:0];
            acc_addr = dst_ext[AW-1:0];
        end else begin
            in_range = (vidx_ext < EW'(VECTOR_DEPTH));
            vec_addr = vidx_ext[AW-1:0];
            acc_addr = vidx_ext[AW-1:0];
        end
    end

    assign o_status.is_load    = is_load;
    assign o_status.is_mac     = is_mac;
    assign o_status.is_read    = is_read;
    assign o_status.in_range   = in_range;
    assign o_status.clear_last = (r_clr_addr == AW'(VECTOR_DEPTH - 1));

    // Saturating add of the truncated product into the accumulator.
    always_comb begin
        sum = {r_acc_rd[ACC_W-1], r_acc_rd[ACC_W-1:0]}
            + {r_prod[PROD_W-1], r_prod[PROD_W-1:FRAC_W]};
        ovf = (sum[ACC_W] != sum[ACC_W-1]);
        if (ovf) begin
            acc_new = {1'b1, (sum[ACC_W] ? ACC_MIN : ACC_MAX)};
        end else begin
            acc_new = {r_acc_rd[ACC_W], sum[ACC_W-1:0]};
        end
    end

    // Accumulator write port: clearing pass, clear on read, or write-back.
    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = acc_addr;
        acc_wdata = '0;
        priority if (i_cmd.clear) begin
            acc_we    = 1'b1;
            acc_waddr = r_clr_addr;
        end else if (i_cmd.exec && is_read && in_range) begin
            acc_we    = 1'b1;
        end else if (i_cmd.accum) begin
            acc_we    = 1'b1;
            acc_wdata = acc_new;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= 1'b0;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_transpose <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_res_valid <= i_cmd.exec && is_read;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_row   <= i_row_index;
            r_col   <= i_col_index;
            r_vidx  <= i_vec_index;
            r_value <= i_value;
        end
    end

    // Vector store: load writes and operand reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch && is_load && in_range) begin
            r_vec_mem[vec_addr] <= r_value;
        end
        if (i_cmd.fetch) begin
            r_vec_rd <= r_vec_mem[vec_addr];
        end
    end

    // Accumulator store.
    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc_mem[acc_waddr] <= acc_wdata;
        end
        if (i_cmd.fetch) begin
            r_acc_rd <= r_acc_mem[acc_addr];
        end
    end

    // Product and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && is_mac) begin
            r_prod <= r_value * $signed(r_vec_rd);
        end
        if (i_cmd.exec && is_read) begin
            r_res_index <= r_vidx;
            r_res_value <= in_range ? r_acc_rd[ACC_W-1:0] : '0;
            r_res_sat   <= in_range ? r_acc_rd[ACC_W] : 1'b0;
        end
    end

    assign o_result_valid  = r_res_valid;
    assign o_out_index     = r_res_index;
    assign o_out_value     = r_res_value;
    assign o_out_saturated = r_res_sat;

endmodule

`default_nettype wire

[hw/rtl/sparse_coo_matvec_accumulate.sv]
// ============================================================================
// sparse_coo_matvec_accumulate
// Coordinate-form sparse matrix times dense vector with saturating Q32.16
// accumulators.
// ============================================================================
// After reset the block clears its accumulator store, one entry per cycle,
// and holds o_busy high until the last entry is cleared. An item is taken
// when i_start is high and o_busy is low; o_busy then stays high while the
// item runs through one sequence of the controller: a vector load ends in
// fetch, a result read passes fetch and execute, and an in-range matrix
// entry passes fetch from the stores, execute (multiply) and accumulate
// (saturating add and write-back). The next item can be taken once o_busy
// is low. A read result appears on the o_out_* ports for exactly one cycle
// with o_result_valid; the receiver cannot hold it off. The transpose
// setting is written through the configuration channel, which is always
// ready, and must only change while the block is idle.
// ============================================================================
`default_nettype none

module sparse_coo_matvec_accumulate #(
    parameter int VECTOR_DEPTH = spmv_pkg::DEFAULT_VECTOR_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic                               i_cfg_data,
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire logic [spmv_pkg::KIND_W-1:0]        i_kind,
    input  wire logic [spmv_pkg::IDX_W-1:0]         i_row_index,
    input  wire logic [spmv_pkg::IDX_W-1:0]         i_col_index,
    input  wire logic [spmv_pkg::IDX_W-1:0]         i_vec_index,
    input  wire logic signed [spmv_pkg::VAL_W-1:0]  i_value,
    output logic                                    o_result_valid,
    output logic [spmv_pkg::IDX_W-1:0]              o_out_index,
    output logic signed [spmv_pkg::ACC_W-1:0]       o_out_value,
    output logic                                    o_out_saturated
);

    spmv_pkg::t_ctrl_cmd  cmd;
    spmv_pkg::t_dp_status status;

    // Configuration beats are always taken.
    assign o_cfg_ready = 1'b1;

    // Controller.
    spmv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // Datapath.
    spmv_dp #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_vec_index     (i_vec_index),
        .i_value         (i_value),
        .o_result_valid  (o_result_valid),
        .o_out_index     (o_out_index),
        .o_out_value     (o_out_value),
        .o_out_saturated (o_out_saturated)
    );

endmodule

`default_nettype wire
